// ===== hdl/postfix_stack_evaluator_assert.svh =====
// ============================================================================
// Postfix stack evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk, reset rst_n.
// ============================================================================
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// Checked only while out of reset
`define PSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included
`define PSE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pse_pkg.sv =====
// ============================================================================
// Postfix stack evaluator package
// Widths, token and state types, operator and error codes.
// ============================================================================
package pse_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Data path
    localparam int DATA_W    = 32;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    // Token queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token kinds
    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_APPLY = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    // Operator codes
    localparam logic [2:0] OPC_ADD = 3'd0;
    localparam logic [2:0] OPC_SUB = 3'd1;
    localparam logic [2:0] OPC_MUL = 3'd2;
    localparam logic [2:0] OPC_DIV = 3'd3;
    localparam logic [2:0] OPC_XOR = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_UNDER = 2'd1;
    localparam logic [1:0] ERR_OVER  = 2'd2;
    localparam logic [1:0] ERR_DIVZ  = 2'd3;

    // Classified token as held in the queue
    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] val;
        logic [2:0]        code;
    } token_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GET_A,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_END
    } state_t;

endpackage

// ===== hdl/pse_queue.sv =====
// ============================================================================
// Token queue
// Small register FIFO that decouples the front from the back end.
// ============================================================================
module pse_queue
    import pse_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    input  token_t push_data,
    output logic   full,
    input  logic   pop_ready,
    output logic   pop_valid,
    output token_t pop_data
);

    token_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    // Pointer and fill level update, pointers wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/pse_front.sv =====
// ============================================================================
// Token front end
// Accepts token requests, classifies them and drops reserved kinds.
// ============================================================================
module pse_front
    import pse_pkg::*;
(
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [31:0] operand_value,
    input  logic [2:0]         operator_code,
    input  logic               q_full,
    output logic               push_valid,
    output token_t             push_data
);

    logic keep_tok;

    // Reserved token kind is accepted and discarded
    assign keep_tok = op inside {KIND_PUSH, KIND_APPLY, KIND_END};

    assign in_ready   = !q_full;
    assign push_valid = in_valid && in_ready && keep_tok;

    // Pack the token for the back end
    always_comb
    begin
        push_data.kind = kind_t'(op);
        push_data.val  = operand_value;
        push_data.code = operator_code;
    end

endmodule

// ===== hdl/pse_divider.sv =====
// ============================================================================
// Signed divider
// Restoring divider, one quotient bit a cycle, truncating towards zero.
// ============================================================================
module pse_divider
    import pse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W:0]      trial;

    // Trial subtract of the shifted partial remainder
    assign trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            // Load magnitudes; most negative value maps onto itself
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            dvs_next  = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

// ===== hdl/pse_back.sv =====
// ============================================================================
// Stack back end
// Executes queued tokens on the operand stack and loads the result register.
// ============================================================================
module pse_back
    import pse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  token_t            q_data,
    output logic              q_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] value,
    output logic [1:0]        error_code
);

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        err_reg, err_next;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic              stk_full;
    logic              stk_short;
    logic              stk_empty;

    logic [DATA_W-1:0] a_reg, a_next;
    logic [2:0]        code_reg, code_next;
    logic [DATA_W-1:0] mul_reg, mul_next;
    logic [DATA_W-1:0] alu_res;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [1:0]        err_out_reg, err_out_next;
    logic              out_free;

    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;

    // First error in an expression wins
    function automatic logic [1:0] note_error(input logic [1:0] cur, input logic [1:0] code);
        return (cur == ERR_NONE) ? code : cur;
    endfunction

    assign cnt_m1    = count_reg - 1'b1;
    assign cnt_m2    = count_reg - CNT_W'(2);
    assign stk_full  = (count_reg >= CNT_W'(STACK_DEPTH));
    assign stk_short = (count_reg < CNT_W'(2));
    assign stk_empty = (count_reg == '0);
    assign out_free  = !out_valid_reg || out_ready;

    // Top entry normally, second entry while A is being captured
    assign rd_addr = (state_reg == ST_GET_A) ? cnt_m2[IDX_W-1:0] : cnt_m1[IDX_W-1:0];

    // Simple operators on B (read data) and A
    always_comb
    begin
        case (code_reg)
            OPC_ADD: alu_res = rd_data_reg + a_reg;
            OPC_SUB: alu_res = rd_data_reg - a_reg;
            OPC_XOR: alu_res = rd_data_reg ^ a_reg;
            default: alu_res = '1;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data.kind == KIND_APPLY && !stk_short)
                    begin
                        state_next = ST_GET_A;
                    end
                    else if (q_data.kind == KIND_END && out_free && !stk_empty)
                    begin
                        state_next = ST_END;
                    end
                end
            end
            ST_GET_A:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (code_reg == OPC_MUL)
                begin
                    state_next = ST_MUL;
                end
                else if (code_reg == OPC_DIV && a_reg != '0)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Stack, error and result register updates
    always_comb
    begin
        q_ready      = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = cnt_m2[IDX_W-1:0];
        wr_data      = '0;
        count_next   = count_reg;
        err_next     = err_reg;
        a_next       = a_reg;
        code_next    = code_reg;
        mul_next     = mul_reg;
        div_start    = 1'b0;
        value_next   = value_reg;
        err_out_next = err_out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_data.kind)
                        KIND_PUSH:
                        begin
                            q_ready = 1'b1;
                            if (stk_full)
                            begin
                                err_next = note_error(err_reg, ERR_OVER);
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = q_data.val;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_APPLY:
                        begin
                            q_ready   = 1'b1;
                            code_next = q_data.code;
                            if (stk_short)
                            begin
                                // Underflow: empty the stack, push zero
                                err_next   = note_error(err_reg, ERR_UNDER);
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = '0;
                                count_next = CNT_W'(1);
                            end
                        end
                        KIND_END:
                        begin
                            if (out_free)
                            begin
                                q_ready = 1'b1;
                                if (stk_empty)
                                begin
                                    value_next     = '0;
                                    err_out_next   = note_error(err_reg, ERR_UNDER);
                                    out_valid_next = 1'b1;
                                    err_next       = ERR_NONE;
                                end
                            end
                        end
                        default:
                        begin
                            q_ready = 1'b1;
                        end
                    endcase
                end
            end
            ST_GET_A:
            begin
                a_next = rd_data_reg;
            end
            ST_EXEC:
            begin
                if (code_reg == OPC_MUL)
                begin
                    mul_next = rd_data_reg * a_reg;
                end
                else if (code_reg == OPC_DIV)
                begin
                    if (a_reg == '0)
                    begin
                        err_next   = note_error(err_reg, ERR_DIVZ);
                        wr_en      = 1'b1;
                        wr_data    = '0;
                        count_next = cnt_m1;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = alu_res;
                    count_next = cnt_m1;
                end
            end
            ST_MUL:
            begin
                wr_en      = 1'b1;
                wr_data    = mul_reg;
                count_next = cnt_m1;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    wr_en      = 1'b1;
                    wr_data    = div_quo;
                    count_next = cnt_m1;
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    value_next     = rd_data_reg;
                    err_out_next   = err_reg;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    err_next       = ERR_NONE;
                end
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
        // Any end token taken clears the stack count, with or without an empty stack
        if (state_reg == ST_IDLE && q_valid && q_data.kind == KIND_END && out_free)
        begin
            count_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        code_reg    <= code_next;
        mul_reg     <= mul_next;
        value_reg   <= value_next;
        err_out_reg <= err_out_next;
    end

    // Stack memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    pse_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (a_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign error_code = err_out_reg;

endmodule

// ===== hdl/postfix_stack_evaluator.sv =====
// ============================================================================
// Postfix stack evaluator
// Evaluates postfix token streams on a 16-entry signed 32-bit stack.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) takes one token request per handshake:
//   op selects push operand, apply operator or end of expression. Output
//   channel (out_valid/out_ready) carries value and error_code once per end
//   token. Tokens pass through a four-entry register queue before the back
//   end sees them. Back end states per token: push, IDLE only; add,
//   subtract and xor, GET_A then EXEC; multiply adds MUL; divide adds DIV for
//   the bit-serial divider that yields one quotient bit per cycle; end, END,
//   or IDLE only with an empty stack. With the back end idle and the queue
//   empty, out_valid rises the cycle after the end token is taken for an
//   empty stack, and after the END state otherwise.
//   Reset clears the stack count, the sticky error, the queue and out_valid
//   at once; result payload and stack entries are not cleared and need no sweep.
//   While out_ready is low the result is held, the back end stops at the
//   next end token and the queue keeps taking tokens until it is full.
// ============================================================================
module postfix_stack_evaluator
    import pse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [31:0] operand_value,
    input  logic [2:0]         operator_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic [1:0]         error_code
);

    logic              q_full;
    logic              q_push;
    token_t            q_push_data;
    logic              q_valid;
    logic              q_ready;
    token_t            q_data;
    logic [DATA_W-1:0] back_value;

    pse_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .operand_value (operand_value),
        .operator_code (operator_code),
        .q_full        (q_full),
        .push_valid    (q_push),
        .push_data     (q_push_data)
    );

    pse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop_ready  (q_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    pse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_ready    (q_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (back_value),
        .error_code (error_code)
    );

    assign value = back_value;

endmodule

// ===== hdl/pse_checker.sv =====
// ============================================================================
// Postfix stack evaluator port checker
// Watches the result channel over time; bound to the top level.
// ============================================================================
`include "postfix_stack_evaluator_assert.svh"

module pse_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] value,
    input logic [1:0]         error_code
);

    // Pending result stays offered
    `PSE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

    // Stalled result keeps its payload
    `PSE_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(value) && $stable(error_code), "result changed while stalled")

    // No result offered during reset
    `PSE_ASSERT_RST(a_rst_quiet, !rst_n |-> !out_valid, "result valid in reset")

    // No result can be ready at the first edge after reset release
    `PSE_ASSERT(a_rst_release, !$past(rst_n) |-> !out_valid, "result valid straight after reset")

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);
